@@ sv/iec104_pkg.sv @@
// Shared types and constants for the IEC 60870-5-104 APCI frame receiver.
// No dependencies; imported by iec104_parser, iec104_out_reg and the top level.
package iec104_pkg;

  localparam logic [7:0] START_OCTET    = 8'h68;
  localparam logic [7:0] SU_LENGTH      = 8'h04;
  localparam logic [7:0] LENGTH_CEILING = 8'd253;
  localparam logic [7:0] HEADER_BYTES   = 8'd6;
  localparam logic [7:0] MAX_LEN_RESET  = 8'd253;

  // U-frame activation control octets and their confirmations
  localparam logic [7:0] CTRL_STARTDT_ACT = 8'h07;
  localparam logic [7:0] CTRL_STOPDT_ACT  = 8'h13;
  localparam logic [7:0] CTRL_TESTFR_ACT  = 8'h43;
  localparam logic [7:0] CTRL_STARTDT_CON = 8'h0B;
  localparam logic [7:0] CTRL_STOPDT_CON  = 8'h23;
  localparam logic [7:0] CTRL_TESTFR_CON  = 8'h83;

  localparam int unsigned OUT_TDATA_W = 40;

  typedef enum logic [1:0] {
    CMD_BYTE     = 2'd0,
    CMD_REL_PRIM = 2'd1,
    CMD_REL_BKUP = 2'd2,
    CMD_NOP      = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    FT_NONE = 2'd0,
    FT_S    = 2'd1,
    FT_U    = 2'd2,
    FT_I    = 2'd3
  } frame_type_t;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'b001,
    PH_HEADER = 3'b010,
    PH_BODY   = 3'b100
  } phase_t;

  typedef struct packed {
    logic        write_valid;
    logic        write_channel;
    logic [7:0]  write_index;
    logic [7:0]  write_data;
    logic        frame_done;
    frame_type_t frame_type;
    logic        frame_channel;
    logic [7:0]  frame_bytes;
    logic        reply_valid;
    logic [7:0]  reply_control;
  } result_t;

  function automatic logic [7:0] confirm_code(input logic [7:0] ctrl);
    logic [7:0] r;
    r = 8'h00;
    if (ctrl == CTRL_STARTDT_ACT)     r = CTRL_STARTDT_CON;
    else if (ctrl == CTRL_STOPDT_ACT) r = CTRL_STOPDT_CON;
    else if (ctrl == CTRL_TESTFR_ACT) r = CTRL_TESTFR_CON;
    return r;
  endfunction

endpackage

@@ sv/iec104_apci_frame_receiver_core.sv @@
// Top level of the IEC 60870-5-104 APCI frame receiver.
// Depends on iec104_pkg, iec104_parser and iec104_out_reg.
//
//  channel | direction | tdata / tuser                         | handshake
//  --------+-----------+---------------------------------------+-----------
//  in_     | slave     | tdata: rx_byte; tuser: command        | tvalid/tready
//  out_    | master    | tdata: write/frame/reply fields       | tvalid/tready
//  cfg_    | write     | cfg_wr_data: max_length_octet         | cfg_wr_en
//
// Each input transaction produces exactly one output transaction in the
// next cycle; parse state updates in the same edge that accepts the input, so a
// new transaction is taken every cycle while the result stream keeps up.
// in_tready drops only while the result register is full and out_tready is low.
// Reset (rst_n low, synchronous) clears the parse state, frees both buffers,
// sets max_length_octet to 253 and empties the result register.
module iec104_apci_frame_receiver_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [1:0]  in_tuser,   // [1:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] write_valid, [1] write_channel, [9:2] write_index, [17:10] write_data,
  // [18] frame_done, [20:19] frame_type, [21] frame_channel,
  // [29:22] frame_bytes, [30] reply_valid, [38:31] reply_control, [39] zero
  output logic [iec104_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);
  import iec104_pkg::*;

  logic    accept;
  logic    space;
  result_t step_res;
  result_t held_res;

  // accept when the result register has room
  assign in_tready = space;
  assign accept    = in_tvalid && space;

  iec104_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .command     (in_tuser),
    .rx_byte     (in_tdata),
    .result      (step_res)
  );

  iec104_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .result     (step_res),
    .space      (space),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_result (held_res)
  );

  // pack fields, first field in the low bits
  assign out_tdata = {1'b0,
                      held_res.reply_control,
                      held_res.reply_valid,
                      held_res.frame_bytes,
                      held_res.frame_channel,
                      held_res.frame_type,
                      held_res.frame_done,
                      held_res.write_data,
                      held_res.write_index,
                      held_res.write_channel,
                      held_res.write_valid};

endmodule

@@ sv/iec104_parser.sv @@
// Frame parser: parse state, buffer ownership and per-byte result logic.
// Depends on iec104_pkg.
module iec104_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [7:0]           cfg_wr_data,
  input  logic                 accept,
  input  logic [1:0]           command,
  input  logic [7:0]           rx_byte,
  output iec104_pkg::result_t  result
);
  import iec104_pkg::*;

  logic [7:0] max_len_r;
  phase_t     phase_r, phase_nxt;
  logic       active_r, active_nxt;
  logic [7:0] bytes_left_r, bytes_left_nxt;
  logic [7:0] next_index_r, next_index_nxt;
  logic [7:0] length_r, length_nxt;
  logic [7:0] ctrl1_r, ctrl1_nxt;
  logic       ctrl3_lsb_r, ctrl3_lsb_nxt;
  logic [1:0] busy_r, busy_nxt;

  logic [7:0] lim;
  logic [7:0] bl_dec;
  logic [7:0] idx_inc;
  logic [7:0] reply;

  assign lim     = (max_len_r > LENGTH_CEILING) ? LENGTH_CEILING : max_len_r;
  assign bl_dec  = (bytes_left_r != 8'd0) ? bytes_left_r - 8'd1 : 8'd0;
  assign idx_inc = next_index_r + 8'd1;
  assign reply   = confirm_code(ctrl1_r);

  always_comb begin
    phase_nxt      = phase_r;
    active_nxt     = active_r;
    bytes_left_nxt = bytes_left_r;
    next_index_nxt = next_index_r;
    length_nxt     = length_r;
    ctrl1_nxt      = ctrl1_r;
    ctrl3_lsb_nxt  = ctrl3_lsb_r;
    busy_nxt       = busy_r;
    result         = '0;

    if (accept) begin
      case (cmd_t'(command))
        CMD_REL_PRIM: busy_nxt[0] = 1'b0;
        CMD_REL_BKUP: busy_nxt[1] = 1'b0;
        CMD_BYTE: begin
          case (phase_r)
            PH_HUNT: begin
              if (rx_byte == START_OCTET && !(busy_r[0] && busy_r[1])) begin
                active_nxt           = busy_r[0];
                next_index_nxt       = 8'd1;
                bytes_left_nxt       = HEADER_BYTES - 8'd1;
                phase_nxt            = PH_HEADER;
                result.write_valid   = 1'b1;
                result.write_channel = busy_r[0];
                result.write_index   = 8'd0;
                result.write_data    = rx_byte;
              end
            end
            PH_HEADER, PH_BODY: begin
              result.write_valid   = 1'b1;
              result.write_channel = active_r;
              result.write_index   = next_index_r;
              result.write_data    = rx_byte;
              if (next_index_r == 8'd1)      length_nxt    = rx_byte;
              else if (next_index_r == 8'd2) ctrl1_nxt     = rx_byte;
              else if (next_index_r == 8'd4) ctrl3_lsb_nxt = rx_byte[0];
              next_index_nxt = idx_inc;
              bytes_left_nxt = bl_dec;
              if (bl_dec == 8'd0) begin
                phase_nxt = PH_HUNT;
                if (phase_r == PH_BODY) begin
                  busy_nxt[active_r]   = 1'b1;
                  result.frame_done    = 1'b1;
                  result.frame_type    = FT_I;
                  result.frame_channel = active_r;
                  result.frame_bytes   = idx_inc;
                end else if (length_r == SU_LENGTH) begin
                  // S or U frame: control octet 3 bit 0 must be clear
                  if (!ctrl3_lsb_r && (ctrl1_r[1:0] == 2'b01 || ctrl1_r[1:0] == 2'b11)) begin
                    busy_nxt[active_r]   = 1'b1;
                    result.frame_done    = 1'b1;
                    result.frame_type    = ctrl1_r[1] ? FT_U : FT_S;
                    result.frame_channel = active_r;
                    result.frame_bytes   = idx_inc;
                    if (ctrl1_r[1] && reply != 8'd0) begin
                      result.reply_valid   = 1'b1;
                      result.reply_control = reply;
                    end
                  end
                end else if (length_r > SU_LENGTH && length_r <= lim &&
                             !ctrl1_r[0] && !ctrl3_lsb_r) begin
                  bytes_left_nxt = length_r - SU_LENGTH;
                  phase_nxt      = PH_BODY;
                end
              end
            end
            default: phase_nxt = PH_HUNT;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r    <= MAX_LEN_RESET;
      phase_r      <= PH_HUNT;
      active_r     <= 1'b0;
      bytes_left_r <= 8'd0;
      next_index_r <= 8'd0;
      length_r     <= 8'd0;
      ctrl1_r      <= 8'd0;
      ctrl3_lsb_r  <= 1'b0;
      busy_r       <= 2'b00;
    end else begin
      if (cfg_wr_en) max_len_r <= cfg_wr_data;
      phase_r      <= phase_nxt;
      active_r     <= active_nxt;
      bytes_left_r <= bytes_left_nxt;
      next_index_r <= next_index_nxt;
      length_r     <= length_nxt;
      ctrl1_r      <= ctrl1_nxt;
      ctrl3_lsb_r  <= ctrl3_lsb_nxt;
      busy_r       <= busy_nxt;
    end
  end

endmodule

@@ sv/iec104_out_reg.sv @@
// Result register: one-entry output stage between parser and result stream.
// Depends on iec104_pkg.
module iec104_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  iec104_pkg::result_t  result,
  output logic                 space,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output iec104_pkg::result_t  out_result
);
  import iec104_pkg::*;

  logic    valid_r;
  result_t data_r;

  // free when empty or when the held result leaves this cycle
  assign space      = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_result = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) data_r <= result;
  end

endmodule
